// File: hdl/rti_pkg.sv
// shared constants and saturating arithmetic for the ray/triangle intersection unit
package rti_pkg;

  // default fraction bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // latency of the split multiplier, input to registered product
  localparam int MUL_LAT = 4;

  // configuration register map
  localparam int NUM_REGS  = 6;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S32_MAX_W = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN_W = 64'shFFFF_FFFF_8000_0000;

  // magnitude of a signed 64-bit value as unsigned
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return m;
  endfunction

  // saturating signed add
  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // saturating signed subtract
  function automatic logic signed [63:0] sub_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX_W) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN_W) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: hdl/rti_delay.sv
// fixed-depth register delay line for side data that rides along the pipeline
module rti_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  // shift line
  always_ff @(posedge clk) begin
    tap_r[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

// File: hdl/rti_mulq.sv
// pipelined fixed-point multiply: 32x32 partial products, truncate toward zero, saturate
module rti_mulq import rti_pkg::*; #(
  parameter int AW        = 33,
  parameter int BW        = 33,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [63:0]   p
);

  logic [63:0]         ua_r;
  logic [63:0]         ub_r;
  logic                neg1_r;
  logic                neg2_r;
  logic                neg3_r;
  logic [63:0]         pp_r [4];
  logic [127:0]        sum_r;
  logic [127:0]        mag_q;
  logic                pos_ovf;
  logic                neg_ovf;
  logic signed [63:0]  p_nxt;

  // operand magnitudes and product sign
  always_ff @(posedge clk) begin
    ua_r   <= mag64(64'(a));
    ub_r   <= mag64(64'(b));
    neg1_r <= a[AW-1] ^ b[BW-1];
  end

  // four 32x32 partial products
  always_ff @(posedge clk) begin
    pp_r[0] <= 64'(ua_r[31:0])  * 64'(ub_r[31:0]);
    pp_r[1] <= 64'(ua_r[31:0])  * 64'(ub_r[63:32]);
    pp_r[2] <= 64'(ua_r[63:32]) * 64'(ub_r[31:0]);
    pp_r[3] <= 64'(ua_r[63:32]) * 64'(ub_r[63:32]);
    neg2_r  <= neg1_r;
  end

  // full product
  always_ff @(posedge clk) begin
    sum_r  <= {64'd0, pp_r[0]} + {32'd0, pp_r[1], 32'd0}
            + {32'd0, pp_r[2], 32'd0} + {pp_r[3], 64'd0};
    neg3_r <= neg2_r;
  end

  // drop fraction bits, saturate, apply sign
  always_comb begin
    mag_q   = sum_r >> FRAC_BITS;
    pos_ovf = |mag_q[127:63];
    neg_ovf = (|mag_q[127:64]) || (mag_q[63] && (|mag_q[62:0]));
    if (neg3_r) begin
      p_nxt = neg_ovf ? S64_MIN : -$signed(mag_q[63:0]);
    end else begin
      p_nxt = pos_ovf ? S64_MAX : $signed(mag_q[63:0]);
    end
  end

  always_ff @(posedge clk) begin
    p <= p_nxt;
  end

endmodule

// File: hdl/rti_divq.sv
// pipelined radix-2 divider, one quotient bit per stage, shared divisor for all lanes
module rti_divq import rti_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int LANES     = 3
) (
  input  logic               clk,
  input  logic signed [63:0] num [LANES],
  input  logic signed [63:0] den,
  output logic signed [31:0] quo [LANES]
);

  localparam int STEPS = 64 + FRAC_BITS;
  localparam int DW    = 64 + FRAC_BITS;
  localparam int QW    = 33;

  logic [63:0]    ud_r  [STEPS+1];
  logic [DW-1:0]  dvd_r [STEPS+1][LANES];
  logic [63:0]    rem_r [STEPS+1][LANES];
  logic [QW-1:0]  q_r   [STEPS+1][LANES];
  logic           big_r [STEPS+1][LANES];
  logic           neg_r [STEPS+1][LANES];

  // operand magnitudes, dividend scaled by the fraction bits
  always_ff @(posedge clk) begin
    ud_r[0] <= mag64(den);
    for (int l = 0; l < LANES; l++) begin
      dvd_r[0][l] <= {mag64(num[l]), {FRAC_BITS{1'b0}}};
      rem_r[0][l] <= '0;
      q_r[0][l]   <= '0;
      big_r[0][l] <= 1'b0;
      neg_r[0][l] <= num[l][63] ^ den[63];
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    // divisor travels with the data
    always_ff @(posedge clk) begin
      ud_r[k+1] <= ud_r[k];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [64:0] trial;
      logic [64:0] diff;
      logic        take;

      // shift in next dividend bit, subtract when it fits
      assign trial = {rem_r[k][l], dvd_r[k][l][DW-1]};
      assign diff  = trial - {1'b0, ud_r[k]};
      assign take  = trial >= {1'b0, ud_r[k]};

      always_ff @(posedge clk) begin
        rem_r[k+1][l] <= take ? diff[63:0] : trial[63:0];
        dvd_r[k+1][l] <= dvd_r[k][l] << 1;
        neg_r[k+1][l] <= neg_r[k][l];
      end

      // high quotient bits only mark overflow
      if (STEPS - 1 - k >= QW) begin : g_high
        always_ff @(posedge clk) begin
          big_r[k+1][l] <= big_r[k][l] | take;
          q_r[k+1][l]   <= q_r[k][l];
        end
      end else begin : g_low
        always_ff @(posedge clk) begin
          big_r[k+1][l] <= big_r[k][l];
          q_r[k+1][l]   <= {q_r[k][l][QW-2:0], take};
        end
      end
    end
  end

  // clamp to signed 32 bits and apply sign
  for (genvar l = 0; l < LANES; l++) begin : g_out
    logic [QW-1:0]      lim;
    logic [QW-1:0]      qs;
    logic signed [31:0] quo_nxt;

    always_comb begin
      lim     = neg_r[STEPS][l] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      qs      = (big_r[STEPS][l] || (q_r[STEPS][l] > lim)) ? lim : q_r[STEPS][l];
      quo_nxt = neg_r[STEPS][l] ? -$signed(qs[31:0]) : $signed(qs[31:0]);
    end

    always_ff @(posedge clk) begin
      quo[l] <= quo_nxt;
    end
  end

endmodule

// File: hdl/ray_triangle_intersect.sv
// top level: ray registers, intersection pipeline and output stage
//
// Tests the ray held in the six configuration registers against one triangle
// per clock (one-sided Moller-Trumbore in signed fixed point, FRAC_BITS
// fraction bits, Q16.16 at the default). busy stays low, so a request is taken
// on every cycle that start is high. Each request gives exactly one result,
// shown for one cycle with out_valid high; the receiver cannot hold results
// off. Most of the pipeline is the divider, which resolves one quotient bit
// per pipeline stage over 64 + FRAC_BITS stages; the multiplies take four
// stages each. Ray registers are read along the pipeline, so rewrite them
// only when no request is in flight.
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // triangle requests
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_vertex_a_x,
  input  logic signed [31:0]  in_vertex_a_y,
  input  logic signed [31:0]  in_vertex_a_z,
  input  logic signed [31:0]  in_vertex_b_x,
  input  logic signed [31:0]  in_vertex_b_y,
  input  logic signed [31:0]  in_vertex_b_z,
  input  logic signed [31:0]  in_vertex_c_x,
  input  logic signed [31:0]  in_vertex_c_y,
  input  logic signed [31:0]  in_vertex_c_z,
  input  logic signed [31:0]  in_given_normal_x,
  input  logic signed [31:0]  in_given_normal_y,
  input  logic signed [31:0]  in_given_normal_z,
  // results
  output logic                out_valid,
  output logic                out_hit,
  output logic signed [31:0]  out_hit_point_x,
  output logic signed [31:0]  out_hit_point_y,
  output logic signed [31:0]  out_hit_point_z,
  output logic signed [31:0]  out_out_normal_x,
  output logic signed [31:0]  out_out_normal_y,
  output logic signed [31:0]  out_out_normal_z,
  output logic signed [31:0]  out_distance,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int NW      = 66 - FRAC_BITS;   // edge normal width
  localparam int QVW     = 65 - FRAC_BITS;   // s x dir width
  localparam int DIV_LAT = 66 + FRAC_BITS;
  localparam int LAT     = 18 + DIV_LAT;
  localparam logic signed [33:0] ONE_Q = 34'sd1 <<< FRAC_BITS;

  localparam int DOT_DN = 0;   // dir . n
  localparam int DOT_SN = 1;   // s . n
  localparam int DOT_UQ = 2;   // e2 . q
  localparam int DOT_VQ = 3;   // e1 . q

  logic signed [31:0]     ray_r [NUM_REGS];
  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   cfg_idx;
  logic signed [31:0]     org [3];
  logic signed [31:0]     dir [3];
  logic signed [31:0]     va [3];
  logic signed [31:0]     vb [3];
  logic signed [31:0]     vc [3];
  logic                   accept;
  logic [LAT-1:0]         valid_r;

  logic signed [32:0]     e1_r [3];
  logic signed [32:0]     e2_r [3];
  logic signed [32:0]     s_r  [3];
  logic [9*33-1:0]        sv_in;
  logic [9*33-1:0]        sv_out;
  logic signed [32:0]     sd  [3];
  logic signed [32:0]     e1d [3];
  logic signed [32:0]     e2d [3];

  logic signed [63:0]     np_a [3];
  logic signed [63:0]     np_b [3];
  logic signed [63:0]     qp_a [3];
  logic signed [63:0]     qp_b [3];
  logic signed [NW-1:0]   n_r  [3];
  logic signed [QVW-1:0]  qv_r [3];

  logic signed [63:0]     prod  [4][3];
  logic signed [63:0]     ps_r  [4];
  logic signed [63:0]     p2_r  [4];
  logic signed [63:0]     dot_r [4];
  logic signed [63:0]     det_r;
  logic signed [63:0]     num_r [3];
  logic [1:0]             flg_d;
  logic signed [31:0]     quo [3];
  logic signed [31:0]     t_dist;
  logic signed [33:0]     w_c;
  logic                   hit_c;
  logic signed [63:0]     hpm [3];
  logic [33:0]            fin_in;
  logic [33:0]            fin_q;
  logic                   hit4;
  logic                   detz4;
  logic signed [31:0]     dist4;
  logic [95:0]            nrm_in;
  logic [95:0]            nrm_q;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ray_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X: ray_r[REG_ORIGIN_X] <= pwdata;
        REG_ORIGIN_Y: ray_r[REG_ORIGIN_Y] <= pwdata;
        REG_ORIGIN_Z: ray_r[REG_ORIGIN_Z] <= pwdata;
        REG_DIR_X:    ray_r[REG_DIR_X]    <= pwdata;
        REG_DIR_Y:    ray_r[REG_DIR_Y]    <= pwdata;
        REG_DIR_Z:    ray_r[REG_DIR_Z]    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X: prdata = ray_r[REG_ORIGIN_X];
      REG_ORIGIN_Y: prdata = ray_r[REG_ORIGIN_Y];
      REG_ORIGIN_Z: prdata = ray_r[REG_ORIGIN_Z];
      REG_DIR_X:    prdata = ray_r[REG_DIR_X];
      REG_DIR_Y:    prdata = ray_r[REG_DIR_Y];
      REG_DIR_Z:    prdata = ray_r[REG_DIR_Z];
      default:      prdata = '0;
    endcase
  end

  assign org[0] = ray_r[REG_ORIGIN_X];
  assign org[1] = ray_r[REG_ORIGIN_Y];
  assign org[2] = ray_r[REG_ORIGIN_Z];
  assign dir[0] = ray_r[REG_DIR_X];
  assign dir[1] = ray_r[REG_DIR_Y];
  assign dir[2] = ray_r[REG_DIR_Z];

  assign va[0] = in_vertex_a_x;
  assign va[1] = in_vertex_a_y;
  assign va[2] = in_vertex_a_z;
  assign vb[0] = in_vertex_b_x;
  assign vb[1] = in_vertex_b_y;
  assign vb[2] = in_vertex_b_z;
  assign vc[0] = in_vertex_c_x;
  assign vc[1] = in_vertex_c_y;
  assign vc[2] = in_vertex_c_z;

  // request handshake and valid pipeline
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[LAT-2:0], accept};
    end
  end

  assign out_valid = valid_r[LAT-1];

  // edges and origin offset
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1_r[i] <= 33'(vb[i]) - 33'(va[i]);
      e2_r[i] <= 33'(vc[i]) - 33'(va[i]);
      s_r[i]  <= 33'(org[i]) - 33'(va[i]);
    end
  end

  // hold s, e1, e2 until the cross products are done
  for (genvar i = 0; i < 3; i++) begin : g_pack
    assign sv_in[33*i +: 33]     = s_r[i];
    assign sv_in[33*(3+i) +: 33] = e1_r[i];
    assign sv_in[33*(6+i) +: 33] = e2_r[i];
    assign sd[i]  = $signed(sv_out[33*i +: 33]);
    assign e1d[i] = $signed(sv_out[33*(3+i) +: 33]);
    assign e2d[i] = $signed(sv_out[33*(6+i) +: 33]);
  end

  rti_delay #(.W(9*33), .DEPTH(MUL_LAT + 1)) u_sv_dly (
    .clk (clk),
    .d   (sv_in),
    .q   (sv_out)
  );

  // cross products n = e1 x e2 and q = s x dir
  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    rti_mulq #(.AW(33), .BW(33), .FRAC_BITS(FRAC_BITS)) u_n_a (
      .clk (clk), .a (e1_r[J]), .b (e2_r[K]), .p (np_a[i])
    );
    rti_mulq #(.AW(33), .BW(33), .FRAC_BITS(FRAC_BITS)) u_n_b (
      .clk (clk), .a (e1_r[K]), .b (e2_r[J]), .p (np_b[i])
    );
    rti_mulq #(.AW(33), .BW(32), .FRAC_BITS(FRAC_BITS)) u_q_a (
      .clk (clk), .a (s_r[J]), .b (dir[K]), .p (qp_a[i])
    );
    rti_mulq #(.AW(33), .BW(32), .FRAC_BITS(FRAC_BITS)) u_q_b (
      .clk (clk), .a (s_r[K]), .b (dir[J]), .p (qp_b[i])
    );

    always_ff @(posedge clk) begin
      n_r[i]  <= NW'(sub_sat64(np_a[i], np_b[i]));
      qv_r[i] <= QVW'(sub_sat64(qp_a[i], qp_b[i]));
    end
  end

  // dot product terms
  for (genvar i = 0; i < 3; i++) begin : g_dot
    rti_mulq #(.AW(32), .BW(NW), .FRAC_BITS(FRAC_BITS)) u_dn (
      .clk (clk), .a (dir[i]), .b (n_r[i]), .p (prod[DOT_DN][i])
    );
    rti_mulq #(.AW(33), .BW(NW), .FRAC_BITS(FRAC_BITS)) u_sn (
      .clk (clk), .a (sd[i]), .b (n_r[i]), .p (prod[DOT_SN][i])
    );
    rti_mulq #(.AW(33), .BW(QVW), .FRAC_BITS(FRAC_BITS)) u_uq (
      .clk (clk), .a (e2d[i]), .b (qv_r[i]), .p (prod[DOT_UQ][i])
    );
    rti_mulq #(.AW(33), .BW(QVW), .FRAC_BITS(FRAC_BITS)) u_vq (
      .clk (clk), .a (e1d[i]), .b (qv_r[i]), .p (prod[DOT_VQ][i])
    );
  end

  // dot sums in two saturating steps
  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      ps_r[l]  <= add_sat64(prod[l][0], prod[l][1]);
      p2_r[l]  <= prod[l][2];
      dot_r[l] <= add_sat64(ps_r[l], p2_r[l]);
    end
  end

  // determinant and numerators
  always_ff @(posedge clk) begin
    det_r    <= sub_sat64(64'sd0, dot_r[DOT_DN]);
    num_r[0] <= dot_r[DOT_SN];
    num_r[1] <= dot_r[DOT_UQ];
    num_r[2] <= sub_sat64(64'sd0, dot_r[DOT_VQ]);
  end

  // distance, u and v
  rti_divq #(.FRAC_BITS(FRAC_BITS), .LANES(3)) u_div (
    .clk (clk),
    .num (num_r),
    .den (det_r),
    .quo (quo)
  );

  rti_delay #(.W(2), .DEPTH(DIV_LAT)) u_flg_dly (
    .clk (clk),
    .d   ({det_r == 64'sd0, det_r > 64'sd1}),
    .q   (flg_d)
  );

  assign t_dist = quo[0];

  // hit test: front face, ahead of origin, inside every edge of the triangle
  always_comb begin
    w_c   = ONE_Q - 34'(quo[1]) - 34'(quo[2]);
    hit_c = flg_d[0] && (t_dist > 32'sd0) && !quo[1][31] && !quo[2][31] && !w_c[33];
  end

  // point on the ray
  for (genvar i = 0; i < 3; i++) begin : g_hp
    rti_mulq #(.AW(32), .BW(32), .FRAC_BITS(FRAC_BITS)) u_hp (
      .clk (clk), .a (dir[i]), .b (t_dist), .p (hpm[i])
    );
  end

  assign fin_in = {hit_c, flg_d[1], t_dist};

  rti_delay #(.W(34), .DEPTH(MUL_LAT)) u_fin_dly (
    .clk (clk),
    .d   (fin_in),
    .q   (fin_q)
  );

  assign hit4  = fin_q[33];
  assign detz4 = fin_q[32];
  assign dist4 = $signed(fin_q[31:0]);

  // output register, zero distance and point for a degenerate det
  always_ff @(posedge clk) begin
    out_hit         <= hit4;
    out_distance    <= detz4 ? 32'sd0 : dist4;
    out_hit_point_x <= detz4 ? 32'sd0 : sat32(add_sat64(64'(org[0]), hpm[0]));
    out_hit_point_y <= detz4 ? 32'sd0 : sat32(add_sat64(64'(org[1]), hpm[1]));
    out_hit_point_z <= detz4 ? 32'sd0 : sat32(add_sat64(64'(org[2]), hpm[2]));
  end

  // normal rides along unchanged
  assign nrm_in = {in_given_normal_z, in_given_normal_y, in_given_normal_x};

  rti_delay #(.W(96), .DEPTH(LAT)) u_nrm_dly (
    .clk (clk),
    .d   (nrm_in),
    .q   (nrm_q)
  );

  assign out_out_normal_x = $signed(nrm_q[31:0]);
  assign out_out_normal_y = $signed(nrm_q[63:32]);
  assign out_out_normal_z = $signed(nrm_q[95:64]);

`ifndef NO_ASSERTIONS
  // every request gives a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("result missing after pipeline latency");

  // a hit always lies ahead of the origin
  a_hit_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_distance > 32'sd0))
    else $error("hit reported with non-positive distance");

  // degenerate det gives no hit and zero distance and point
  a_det_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[LAT-2] && detz4) |=>
      (!out_hit && out_distance == 32'sd0 && out_hit_point_x == 32'sd0 &&
       out_hit_point_y == 32'sd0 && out_hit_point_z == 32'sd0))
    else $error("zero det result not cleared");
`endif

endmodule

// File: sim/tb.sv
// testbench for the ray/triangle intersection unit: scoreboard, drivers and stimulus
module tb import rti_pkg::*; ();

  localparam logic signed [63:0] ONE = 64'sd65536;

  typedef struct {
    logic signed [31:0] vtx [9];
    logic signed [31:0] nrm [3];
  } triangle_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] hp [3];
    logic signed [31:0] nrm [3];
    logic signed [31:0] t_dist;
  } hit_result_t;

  // expected-hit store with its own copy of the ray registers
  class hit_scoreboard;
    logic signed [63:0] org [3];
    logic signed [63:0] dir [3];
    hit_result_t pending_hits [$];
    int errors;

    function new();
      foreach (org[i]) begin
        org[i] = 0;
        dir[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      if (idx < 3) org[idx] = 64'(signed'(val));
      else if (idx < 6) dir[idx - 3] = 64'(signed'(val));
    endfunction

    function logic [63:0] mag(logic signed [63:0] a);
      return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function logic signed [63:0] add_s(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
    endfunction

    function logic signed [63:0] sub_s(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) - 65'(b);
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
    endfunction

    // exact product, truncated toward zero, saturated
    function logic signed [63:0] mul_q(logic signed [63:0] a, logic signed [63:0] b);
      logic [127:0] ua, ub, p;
      ua = {64'b0, mag(a)};
      ub = {64'b0, mag(b)};
      p = (ua * ub) >> 16;
      if (a[63] ^ b[63]) begin
        if (p >= 128'h8000_0000_0000_0000) return S64_MIN;
        return -$signed(p[63:0]);
      end
      if (p > 128'h7FFF_FFFF_FFFF_FFFF) return S64_MAX;
      return p[63:0];
    endfunction

    // shifted quotient, truncated toward zero, saturated to 32 bits
    function logic signed [63:0] div_q(logic signed [63:0] n, logic signed [63:0] d);
      logic [127:0] num, q, lim;
      logic neg;
      neg = n[63] ^ d[63];
      num = {64'b0, mag(n)} << 16;
      q = num / {64'b0, mag(d)};
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) q = lim;
      return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function logic signed [63:0] dot(logic signed [63:0] a [3], logic signed [63:0] b [3]);
      return add_s(add_s(mul_q(a[0], b[0]), mul_q(a[1], b[1])), mul_q(a[2], b[2]));
    endfunction

    function void cross3(input logic signed [63:0] a [3], input logic signed [63:0] b [3],
                         output logic signed [63:0] r [3]);
      r[0] = sub_s(mul_q(a[1], b[2]), mul_q(a[2], b[1]));
      r[1] = sub_s(mul_q(a[2], b[0]), mul_q(a[0], b[2]));
      r[2] = sub_s(mul_q(a[0], b[1]), mul_q(a[1], b[0]));
    endfunction

    function logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > S32_MAX_W) return 32'sh7FFF_FFFF;
      if (v < S32_MIN_W) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // one-sided intersection of the held ray with a triangle
    function hit_result_t predict_hit(triangle_t tg);
      hit_result_t r;
      logic signed [63:0] e1 [3], e2 [3], s [3], n [3], q [3];
      logic signed [63:0] det, td, u, v, w;
      td = 0; u = 0; v = 0;
      for (int i = 0; i < 3; i++) begin
        e1[i] = 64'(tg.vtx[3 + i]) - 64'(tg.vtx[i]);
        e2[i] = 64'(tg.vtx[6 + i]) - 64'(tg.vtx[i]);
        s[i] = org[i] - 64'(tg.vtx[i]);
      end
      cross3(e1, e2, n);
      cross3(s, dir, q);
      det = sub_s(0, dot(dir, n));
      if (det != 0) begin
        td = div_q(dot(s, n), det);
        u = div_q(dot(e2, q), det);
        v = div_q(sub_s(0, dot(e1, q)), det);
      end
      w = ONE - u - v;
      r.hit = det > 1 && td >= 1 && u >= 0 && v >= 0 && w >= 0;
      for (int i = 0; i < 3; i++) begin
        r.hp[i] = det != 0 ? clamp32(add_s(org[i], mul_q(dir[i], td))) : 32'sd0;
        r.nrm[i] = tg.nrm[i];
      end
      r.t_dist = td[31:0];
      return r;
    endfunction

    function void note_triangle(triangle_t tg);
      pending_hits.push_back(predict_hit(tg));
    endfunction

    function void report(string fld, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, fld,
                 $signed(exp_v), $signed(act_v));
        errors++;
      end
    endfunction

    function void check_result(hit_result_t act);
      hit_result_t e;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none actual distance %0d", $time,
                 act.t_dist);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      report("hit", 32'(e.hit), 32'(act.hit));
      report("hit_point_x", e.hp[0], act.hp[0]);
      report("hit_point_y", e.hp[1], act.hp[1]);
      report("hit_point_z", e.hp[2], act.hp[2]);
      report("normal_x", e.nrm[0], act.nrm[0]);
      report("normal_y", e.nrm[1], act.nrm[1]);
      report("normal_z", e.nrm[2], act.nrm[2]);
      report("distance", e.t_dist, act.t_dist);
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic signed [31:0] vtx [9];
  logic signed [31:0] nrm [3];
  logic out_valid, out_hit;
  logic signed [31:0] out_hp_x, out_hp_y, out_hp_z, out_n_x, out_n_y, out_n_z, out_dist;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  hit_scoreboard sb = new();
  int idle_pct;

  ray_triangle_intersect dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vertex_a_x(vtx[0]), .in_vertex_a_y(vtx[1]), .in_vertex_a_z(vtx[2]),
    .in_vertex_b_x(vtx[3]), .in_vertex_b_y(vtx[4]), .in_vertex_b_z(vtx[5]),
    .in_vertex_c_x(vtx[6]), .in_vertex_c_y(vtx[7]), .in_vertex_c_z(vtx[8]),
    .in_given_normal_x(nrm[0]), .in_given_normal_y(nrm[1]), .in_given_normal_z(nrm[2]),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_hit_point_x(out_hp_x), .out_hit_point_y(out_hp_y), .out_hit_point_z(out_hp_z),
    .out_out_normal_x(out_n_x), .out_out_normal_y(out_n_y), .out_out_normal_z(out_n_z),
    .out_distance(out_dist),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // note accepted requests and check results
  always @(posedge clk) begin
    triangle_t tg;
    hit_result_t r;
    if (rst_n && start && !busy) begin
      foreach (vtx[i]) tg.vtx[i] = vtx[i];
      foreach (nrm[i]) tg.nrm[i] = nrm[i];
      sb.note_triangle(tg);
    end
    if (rst_n && out_valid) begin
      r.hit = out_hit;
      r.hp[0] = out_hp_x; r.hp[1] = out_hp_y; r.hp[2] = out_hp_z;
      r.nrm[0] = out_n_x; r.nrm[1] = out_n_y; r.nrm[2] = out_n_z;
      r.t_dist = out_dist;
      sb.check_result(r);
    end
  end

  // wait until the pipeline has drained
  task automatic drain();
    @(posedge clk);
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // register write, setup then access
  task automatic write_reg(int idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.set_reg(idx, val);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
    drain();
    write_reg(REG_ORIGIN_X, ox); write_reg(REG_ORIGIN_Y, oy); write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx); write_reg(REG_DIR_Y, dy); write_reg(REG_DIR_Z, dz);
  endtask

  // maybe idle some cycles, then drive one request and hold it until taken
  task automatic send(triangle_t tg);
    bit ok;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    foreach (vtx[i]) vtx[i] <= tg.vtx[i];
    foreach (nrm[i]) nrm[i] <= tg.nrm[i];
    forever begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
      if (ok) break;
    end
  endtask

  task automatic stop_sending();
    start <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] unit(int k);
    return 32'(k * 65536);
  endfunction

  function automatic triangle_t make_tri(int ax, ay, az, bx, by, bz, cx, cy, cz);
    triangle_t tg;
    tg.vtx[0] = unit(ax); tg.vtx[1] = unit(ay); tg.vtx[2] = unit(az);
    tg.vtx[3] = unit(bx); tg.vtx[4] = unit(by); tg.vtx[5] = unit(bz);
    tg.vtx[6] = unit(cx); tg.vtx[7] = unit(cy); tg.vtx[8] = unit(cz);
    foreach (tg.nrm[i]) tg.nrm[i] = $urandom();
    return tg;
  endfunction

  function automatic triangle_t noise_tri();
    triangle_t tg;
    foreach (tg.vtx[i]) tg.vtx[i] = $urandom();
    foreach (tg.nrm[i]) tg.nrm[i] = $urandom();
    return tg;
  endfunction

  // triangle placed around a point ahead of the ray, random winding
  function automatic triangle_t aimed_tri();
    triangle_t tg;
    logic signed [63:0] t, p;
    t = $urandom_range(65536 / 4, 65536 * 6);
    for (int i = 0; i < 3; i++) begin
      p = sb.org[i] + ((sb.dir[i] * t) >>> 16);
      for (int k = 0; k < 3; k++)
        tg.vtx[3 * k + i] = 32'(p + $signed(64'($urandom_range(0, 6 * 65536))) - 3 * 65536);
    end
    foreach (tg.nrm[i]) tg.nrm[i] = $urandom();
    return tg;
  endfunction

  function automatic logic [31:0] small_val();
    return 32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++)
      send($urandom_range(99) < 80 ? aimed_tri() : noise_tri());
    stop_sending();
  endtask

  task automatic random_ray();
    set_ray(small_val(), small_val(), small_val(), small_val(), small_val(), small_val());
  endtask

  // stimulus
  initial begin
    triangle_t tg;
    rst_n <= 0; start <= 0;
    foreach (vtx[i]) vtx[i] <= 0;
    foreach (nrm[i]) nrm[i] <= 0;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
    idle_pct = 12;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset ray: zero direction, det always zero
    send(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    stop_sending();

    // ray down +z from z=-10
    set_ray(0, 0, unit(-10), 0, 0, unit(1));
    send(make_tri(-1, -1, 0, -1, 2, 0, 2, -1, 0));     // front face
    send(make_tri(-1, -1, 0, 2, -1, 0, -1, 2, 0));     // back face
    send(make_tri(3, 3, 0, 3, 5, 0, 5, 3, 0));         // plane hit, outside
    send(make_tri(0, 0, 0, 0, 2, 0, 2, 0, 0));         // on a vertex
    send(make_tri(0, -1, 0, 0, 2, 0, 2, -1, 0));       // on an edge
    send(make_tri(-1, -1, -20, -1, 2, -20, 2, -1, -20)); // behind the origin
    send(make_tri(1, 1, 1, 1, 1, 1, 1, 1, 1));         // degenerate, det zero
    send(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tg.vtx = '{default: 32'sh7FFF_FFFF};
    tg.nrm = '{default: 32'sh7FFF_FFFF};
    send(tg);
    tg.vtx = '{default: 32'sh8000_0000};
    tg.nrm = '{default: 32'sh8000_0000};
    send(tg);
    tg.vtx = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
               32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000};
    send(tg);
    tg.vtx = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
    send(tg);
    tg.vtx = '{default: 32'sh0000_0001};
    tg.vtx[4] = 32'sh0000_0002; tg.vtx[6] = 32'sh0000_0002;
    send(tg);
    stop_sending();

    // write outside the map is ignored
    drain();
    write_reg(6, 32'hFFFF_FFFF);
    send(make_tri(-1, -1, 0, -1, 2, 0, 2, -1, 0));
    stop_sending();

    // extreme rays
    set_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int k = 0; k < 4; k++) send(noise_tri());
    send(make_tri(-1, -1, 0, -1, 2, 0, 2, -1, 0));
    stop_sending();
    set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    for (int k = 0; k < 4; k++) send(noise_tri());
    stop_sending();
    set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    random_phase(30);

    // random rays, sender idles rarely then often then never
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = ph < 4 ? 12 : (ph < 8 ? 54 : 0);
      random_ray();
      random_phase(100);
    end

    drain();
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule

// File: files.f
hdl/rti_pkg.sv
hdl/rti_delay.sv
hdl/rti_mulq.sv
hdl/rti_divq.sv
hdl/ray_triangle_intersect.sv
sim/tb.sv
